// ===== sv/twrm_pkg.sv =====
// Shared types and constants for the three-wire register read master.
package twrm_pkg;

    // Request codes carried by the req_type field.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Fixed widths of the address and read-data fields.
    localparam int ADDR_BITS = 8;
    localparam int READ_BITS = 8;

    // One result beat, as it leaves the sequencing logic.
    typedef struct packed {
        logic                 chip_enable;
        logic                 serial_clock;
        logic                 data_out;
        logic                 data_drive;
        logic                 busy;
        logic                 done;
        logic [READ_BITS-1:0] read_data;
    } t_result;

endpackage

// ===== sv/twrm_core.sv =====
// Transfer sequencer: line state, half-period counter and address/data shifters.
module twrm_core #(
    parameter int WORD_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_req_type,
    input  logic [twrm_pkg::ADDR_BITS-1:0]   i_reg_addr,
    input  logic                             i_io_in,
    output twrm_pkg::t_result                o_result
);
    import twrm_pkg::*;

    localparam int PHASE_TICKS = 2 * WORD_BITS;
    localparam int CNT_W       = $clog2(PHASE_TICKS);

    logic                 r_active,  n_active;
    logic                 r_reading, n_reading;
    logic [CNT_W-1:0]     r_count,   n_count;
    logic [WORD_BITS-1:0] r_addr,    n_addr;
    logic [WORD_BITS-1:0] r_data,    n_data;
    logic                 r_clk,     n_clk;
    logic                 w_done;
    logic                 w_last;

    assign w_last = (r_count == CNT_W'(PHASE_TICKS - 1));

    always_comb begin
        n_active  = r_active;
        n_reading = r_reading;
        n_count   = r_count;
        n_addr    = r_addr;
        n_data    = r_data;
        n_clk     = r_clk;
        w_done    = 1'b0;
        if (!r_active) begin
            if (i_req_type == REQ_START) begin
                n_active  = 1'b1;
                n_reading = 1'b0;
                n_count   = '0;
                n_clk     = 1'b0;
                n_addr    = WORD_BITS'(i_reg_addr);
                n_data    = '0;
            end
        end else if (i_req_type == REQ_TICK) begin
            // Even ticks raise the clock, odd ticks lower it.
            n_clk = ~r_count[0];
            if (!r_reading) begin
                // The next address bit is presented as the clock falls.
                if (r_count[0]) begin
                    n_addr = r_addr >> 1;
                end
            end else if (!r_count[0]) begin
                // Sample just before the rising edge; bits arrive LSB first,
                // so they enter at the top and move down.
                n_data = (r_data >> 1) | (WORD_BITS'(i_io_in) << (WORD_BITS - 1));
            end
            if (w_last) begin
                n_count = '0;
                if (!r_reading) begin
                    n_reading = 1'b1;
                end else begin
                    n_active  = 1'b0;
                    n_reading = 1'b0;
                    w_done    = 1'b1;
                end
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_result.chip_enable  = n_active;
        o_result.serial_clock = n_clk;
        o_result.data_drive   = n_active & ~n_reading;
        o_result.data_out     = n_active & ~n_reading & n_addr[0];
        o_result.busy         = n_active;
        o_result.done         = w_done;
        o_result.read_data    = w_done ? READ_BITS'(n_data) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_reading <= 1'b0;
            r_count   <= '0;
            r_addr    <= '0;
            r_data    <= '0;
            r_clk     <= 1'b0;
        end else if (i_step) begin
            r_active  <= n_active;
            r_reading <= n_reading;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_data    <= n_data;
            r_clk     <= n_clk;
        end
    end

`ifndef SYNTHESIS
    a_read_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reading |-> r_active)
        else $error("read phase flagged without an active transfer");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PHASE_TICKS - 1))
        else $error("half-period counter beyond phase length");

    a_end_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) |-> $past(i_step) && $past(r_reading) && $past(w_last))
        else $error("transfer ended outside the last read tick");

    a_done_drops_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done |-> !o_result.chip_enable && !o_result.data_drive)
        else $error("done reported while the transfer is still active");
`endif

endmodule

// ===== sv/twrm_out_reg.sv =====
// Output register that holds one result beat until the consumer takes it.
module twrm_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  twrm_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output twrm_pkg::t_result o_result
);
    import twrm_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The slot can take a new beat when empty or when its beat leaves now.
    assign o_free   = ~r_valid | i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load | (r_valid & ~i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sv/three_wire_register_read_master.sv =====
// Top level of the three-wire serial register read master (LSB first).
//
//  Channel   Valid     Ready     Payload
//  -------   -------   -------   ---------------------------------------------
//  request   i_valid   o_ready   i_req_type, i_reg_addr, i_io_in
//  result    o_valid   i_ready   o_chip_enable, o_serial_clock, o_data_out,
//                                o_data_drive, o_busy_res, o_done_res,
//                                o_read_data
//
// Every request beat produces exactly one result beat, in the cycle after it is
// accepted. A beat is taken in every cycle as long as the result register is
// empty or being emptied, so the sustained rate is one beat per clock; the
// single output register is the only thing that sets it.
// Reset (i_rst_n low at a rising edge) returns the master to idle with the
// serial clock low and the result register empty.
// When the consumer stalls, one result waits in the output register and the
// request side stalls with it; no beat is lost or repeated.
//
// A start beat while idle loads the address and raises chip enable. Each
// following tick beat is one half serial-clock period: 2*WORD_BITS ticks
// drive the address out, then 2*WORD_BITS ticks read the data byte in, and
// the last of these reports the byte with done set. A start beat during a
// transfer leaves everything as it is; a tick while idle reports all lines low.
module three_wire_register_read_master #(
    parameter int WORD_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [twrm_pkg::ADDR_BITS-1:0] i_reg_addr,
    input  logic                           i_io_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_chip_enable,
    output logic                           o_serial_clock,
    output logic                           o_data_out,
    output logic                           o_data_drive,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [twrm_pkg::READ_BITS-1:0] o_read_data
);
    import twrm_pkg::*;

    logic    w_free;
    logic    w_step;
    t_result w_next;
    t_result w_out;

    // A request beat moves the sequencer and fills the result register at once.
    assign o_ready = w_free;
    assign w_step  = i_valid & w_free;

    twrm_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_req_type (i_req_type),
        .i_reg_addr (i_reg_addr),
        .i_io_in    (i_io_in),
        .o_result   (w_next)
    );

    twrm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_result (w_next),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_free   (w_free),
        .o_result (w_out)
    );

    // The result beat fans out onto the individual line-level ports.
    assign o_chip_enable  = w_out.chip_enable;
    assign o_serial_clock = w_out.serial_clock;
    assign o_data_out     = w_out.data_out;
    assign o_data_drive   = w_out.data_drive;
    assign o_busy_res     = w_out.busy;
    assign o_done_res     = w_out.done;
    assign o_read_data    = w_out.read_data;

endmodule

// ===== tb/three_wire_register_read_master_test.sv =====
// Self-checking testbench for the three-wire serial register read master.
`timescale 1ns / 100ps

module three_wire_register_read_master_test;

    import twrm_pkg::*;

    // The block is built with its default word size; the predictor follows it.
    localparam int WORD_BITS   = 8;
    localparam int PHASE_TICKS = 2 * WORD_BITS;
    // Request beats that do real work (ignored ones are not counted).
    localparam int ITEMS       = 1950;
    // Cycles the result side refuses beats during a long hold-off.
    localparam int HOLD_CYCLES = 300;

    // One row of the directed table. Where pinned is set, want is the result
    // that can be read straight off the behavior and replaces the predictor.
    typedef struct packed {
        logic       req;
        logic [7:0] addr;
        logic       io;
        logic       pinned;
        t_result    want;
    } t_stim_row;

    // What the request side offered, kept until the beat is accepted.
    typedef struct packed {
        logic    pinned;
        t_result want;
    } t_offer;

    // All lines low: a tick while idle right after reset.
    localparam t_result ALL_LOW = '0;
    // Lines just after a start with address 8'hFF: chip enable up, clock
    // low, bit 0 of the address (a one) on the data line.
    localparam t_result LOADED_FF = '{chip_enable: 1'b1, serial_clock: 1'b0,
                                      data_out: 1'b1, data_drive: 1'b1,
                                      busy: 1'b1, done: 1'b0, read_data: 8'h00};

    // Directed part: a tick while idle, a start at the top address, a start
    // at the bottom address while busy (must be ignored), then the sixteen
    // address ticks and the first read ticks. The random part picks up the
    // open transfer and finishes it.
    localparam int N_DIRECTED = 23;
    localparam t_stim_row DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{REQ_TICK,  8'hFF, 1'b1, 1'b1, ALL_LOW},
        '{REQ_START, 8'hFF, 1'b0, 1'b1, LOADED_FF},
        '{REQ_START, 8'h00, 1'b1, 1'b1, LOADED_FF},
        '{REQ_TICK,  8'h00, 1'b0, 1'b0, ALL_LOW}, '{REQ_TICK, 8'hFF, 1'b1, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h5A, 1'b0, 1'b0, ALL_LOW}, '{REQ_TICK, 8'hA5, 1'b1, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b1, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b0, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b1, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b0, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b0, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b1, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b0, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b1, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b1, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b1, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b0, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b0, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b1, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b0, 1'b0, ALL_LOW},
        '{REQ_TICK,  8'h00, 1'b0, 1'b0, ALL_LOW}, '{REQ_TICK, 8'h00, 1'b1, 1'b0, ALL_LOW}
    };

    // Clock, reset and the two channels. Every input starts at a known level.
    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic                 i_req_type = REQ_TICK;
    logic [ADDR_BITS-1:0] i_reg_addr = '0;
    logic                 i_io_in    = 1'b0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic                 o_chip_enable;
    logic                 o_serial_clock;
    logic                 o_data_out;
    logic                 o_data_drive;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic [READ_BITS-1:0] o_read_data;

    // Shadow of the master's state, advanced once per accepted request beat.
    logic                 xfer_on   = 1'b0;
    logic                 in_read   = 1'b0;
    logic [4:0]           half_tick = '0;
    logic [WORD_BITS-1:0] addr_sh   = '0;
    logic [WORD_BITS-1:0] rx_sh     = '0;
    logic                 sclk_q    = 1'b0;

    // Lines the master must show, oldest first, and the offers in flight.
    t_result expected_q [$];
    t_offer  offer_q [$];

    // Sender bookkeeping: ticks still owed to the open transfer, as the
    // request side sees it, and the size of the current burst.
    int ticks_owed = 0;
    int burst_left = 0;
    int n_counted  = 0;
    int n_ignored  = 0;
    int n_starts   = 0;
    int n_reads    = 0;
    int n_holds    = 0;
    int n_fail     = 0;
    logic hold_req = 1'b0;

    three_wire_register_read_master #(
        .WORD_BITS(WORD_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_reg_addr    (i_reg_addr),
        .i_io_in       (i_io_in),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_chip_enable (o_chip_enable),
        .o_serial_clock(o_serial_clock),
        .o_data_out    (o_data_out),
        .o_data_drive  (o_data_drive),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_data   (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A hang anywhere ends the run here. The slowest legal run is a few
    // hundred thousand nanoseconds; this is many times that.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Advances the shadow state by one request beat and returns the line
    // levels the master must report for it. A start only counts while idle,
    // a tick only while a transfer is open. Even ticks raise the serial
    // clock (sampling the data line first in the read half), odd ticks lower
    // it and, in the address half, move the next address bit out.
    function automatic t_result line_levels_after(logic req, logic [7:0] addr, logic io);
        t_result r;
        r = '0;
        if (!xfer_on) begin
            if (req == REQ_START) begin
                xfer_on   = 1'b1;
                in_read   = 1'b0;
                half_tick = '0;
                sclk_q    = 1'b0;
                addr_sh   = WORD_BITS'(addr);
                rx_sh     = '0;
            end
        end else if (req == REQ_TICK) begin
            if (!half_tick[0]) begin
                if (in_read && io) begin
                    rx_sh[half_tick[3:1]] = 1'b1;
                end
                sclk_q = 1'b1;
            end else begin
                sclk_q = 1'b0;
                if (!in_read) begin
                    addr_sh = addr_sh >> 1;
                end
            end
            if (half_tick == 5'(PHASE_TICKS - 1)) begin
                half_tick = '0;
                if (in_read) begin
                    xfer_on     = 1'b0;
                    r.done      = 1'b1;
                    r.read_data = READ_BITS'(rx_sh);
                end
                in_read = !in_read;
            end else begin
                half_tick = half_tick + 5'd1;
            end
        end
        r.chip_enable  = xfer_on;
        r.busy         = xfer_on;
        r.serial_clock = sclk_q;
        r.data_drive   = xfer_on && !in_read;
        r.data_out     = r.data_drive && addr_sh[0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Offers one request beat and returns at the edge that accepts it.
    // Bursts of random length are separated by random gaps; now and then a
    // long burst gives a stretch with no idling at all. valid is only
    // lowered when a real gap follows, so it never drops and rises within
    // one time step.
    task automatic send_beat(logic req, logic [7:0] addr, logic io,
                             logic pinned, t_result want);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        offer_q.push_back('{pinned: pinned, want: want});
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_reg_addr <= addr;
        i_io_in    <= io;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        burst_left--;
        // Keep the sender's view of the transfer in step with the beat.
        if (req == REQ_START && ticks_owed == 0) begin
            ticks_owed = 2 * PHASE_TICKS;
            n_starts++;
            n_counted++;
        end else if (req == REQ_TICK && ticks_owed > 0) begin
            ticks_owed--;
            n_counted++;
        end else begin
            n_ignored++;
        end
    endtask

    // The request side goes quiet until every expected result has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // Result side. It changes its stall pattern at random intervals:
    // always ready, mostly ready, mostly stalled, or ready one cycle in
    // three. A hold-off request from the stimulus makes it refuse beats for
    // a long, counted stretch so the output register fills and the request
    // side backs up behind it.
    initial begin : result_side
        int hold_left;
        int mode_left;
        int mode;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                n_holds++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    // Scoreboard. Both handshakes are sampled at the edge with the values
    // that stood before it. The request beat is predicted first so that a
    // result in the same cycle would still find its expectation.
    always @(posedge i_clk) begin
        t_offer  ofr;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                ofr  = offer_q.pop_front();
                want = line_levels_after(i_req_type, i_reg_addr, i_io_in);
                if (ofr.pinned) begin
                    want = ofr.want;
                end
                expected_q.push_back(want);
            end
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no request beat behind it");
                    n_fail++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("chip_enable", 8'(want.chip_enable), 8'(o_chip_enable));
                    check_field("serial_clock", 8'(want.serial_clock), 8'(o_serial_clock));
                    check_field("data_out", 8'(want.data_out), 8'(o_data_out));
                    check_field("data_drive", 8'(want.data_drive), 8'(o_data_drive));
                    check_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                    check_field("done_res", 8'(want.done), 8'(o_done_res));
                    check_field("read_data", want.read_data, o_read_data);
                    if (want.done) begin
                        n_reads++;
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then whole transfers with random
    // content, salted with ignored beats (ticks while idle, starts while
    // busy), drains and long result-side hold-offs.
    initial begin : stimulus
        logic [7:0] rx_pattern;
        logic [7:0] addr;
        logic       io;
        int         pos;
        rx_pattern = 8'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_beat(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].addr, DIRECTED_ROWS[k].io,
                      DIRECTED_ROWS[k].pinned, DIRECTED_ROWS[k].want);
        end

        // Pause mid-transfer until everything is back, then hold off the
        // result side while beats keep coming.
        drain_results();
        hold_req = 1'b1;

        while (n_counted < ITEMS) begin
            if (ticks_owed == 0) begin
                // Between transfers: sometimes pause, sometimes hold off
                // the result side, sometimes throw in a tick while idle.
                if ($urandom_range(0, 11) == 0) begin
                    drain_results();
                end
                if ($urandom_range(0, 29) == 0) begin
                    hold_req = 1'b1;
                end
                case ($urandom_range(0, 3))
                    0:       rx_pattern = 8'h00;
                    1:       rx_pattern = 8'hFF;
                    default: rx_pattern = 8'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0:       addr = 8'h00;
                    1:       addr = 8'hFF;
                    default: addr = 8'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(REQ_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
                end else begin
                    send_beat(REQ_START, addr, 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end else if ($urandom_range(0, 19) == 0) begin
                // A start during a transfer must change nothing.
                send_beat(REQ_START, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                // On read-half sampling ticks the data line carries the
                // chosen byte; everywhere else it is noise.
                pos = 2 * PHASE_TICKS - ticks_owed;
                if (pos >= PHASE_TICKS && (pos - PHASE_TICKS) % 2 == 0) begin
                    io = rx_pattern[((pos - PHASE_TICKS) / 2) % 8];
                end else begin
                    io = 1'($urandom_range(0, 1));
                end
                send_beat(REQ_TICK, 8'($urandom), io, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d working request beats and %0d ignored ones.", n_counted, n_ignored);
        $display("%0d transfers started, %0d bytes read back, %0d long hold-offs.",
                 n_starts, n_reads, n_holds);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
